/* rtl/core/h2r_pkg.sv */
// Package for the HSL to RGB converter: field widths, hue and sector spans,
// and the reciprocal constants for the final divide by 600.
// No dependencies.
`default_nettype none

package h2r_pkg;

  localparam int FIELD_W       = 14;   // input field width, signed
  localparam int CH_W          = 8;    // output channel width
  localparam int NUM_CH        = 3;
  localparam int CH_RED        = 0;
  localparam int CH_GREEN      = 1;
  localparam int CH_BLUE       = 2;
  localparam int CH_MAX        = 255;

  localparam int FRAC_BITS_DEF = 12;

  localparam int HUE_WRAP      = 3600;
  localparam int HUE_W         = 12;   // holds 0..3599
  localparam int HUE_OFS_W     = 15;   // holds hue + 3 * HUE_WRAP
  localparam int SECTOR_SPAN   = 600;
  localparam int SPAN_W        = 10;   // holds 0..600
  localparam int U_W           = 10;   // signed weight -300..300
  localparam int U_HALF        = 300;

  // z / 600 for z < 2**Z_W: q0 = (z * RECIP) >> RECIP_SHIFT, low by at most one
  localparam int Z_W           = 18;
  localparam int RECIP         = 447392;
  localparam int RECIP_W       = 19;
  localparam int RECIP_SHIFT   = 28;
  localparam int Q_W           = 9;

  localparam int NUM_STAGES    = 7;

endpackage

`default_nettype wire

/* rtl/core/h2r_in_if.sv */
// Input channel of the HSL to RGB converter: valid/ready and the HSL item.
// Depends on h2r_pkg.
`default_nettype none

interface h2r_in_if
  import h2r_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] hue_tenths;
  logic signed [FIELD_W-1:0] saturation_q12;
  logic signed [FIELD_W-1:0] lightness_q12;

  modport source (output valid, hue_tenths, saturation_q12, lightness_q12, input ready);
  modport sink   (input valid, hue_tenths, saturation_q12, lightness_q12, output ready);
endinterface

`default_nettype wire

/* rtl/core/h2r_out_if.sv */
// Result channel of the HSL to RGB converter: valid/ready and the RGB item.
// Depends on h2r_pkg.
`default_nettype none

interface h2r_out_if
  import h2r_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

/* rtl/core/hsl_to_rgb_converter.sv */
// HSL to RGB converter, 7-stage pipeline. An accepted item moves through the stage
// registers s1 to s7 in order and leaves from s7 when the output is ready.
// Throughput: one item per cycle unless the output stalls; each stage has its own
// valid bit and load enable, so bubbles collapse and a stalled output still lets
// upstream stages fill. Reset (rst_n low, synchronous) clears all stage valid bits;
// data regs are not reset. Depends on h2r_pkg, h2r_in_if, h2r_out_if.
`default_nettype none

module hsl_to_rgb_converter
  import h2r_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  h2r_in_if.sink     in_ch,
  h2r_out_if.source  out_ch
);

  localparam int ONE_W  = FRAC_BITS + 1;
  localparam int CMP_W  = (FIELD_W > FRAC_BITS + 2) ? FIELD_W : FRAC_BITS + 2;
  localparam int K_W    = 2 * FRAC_BITS + 1;
  localparam int LM_W   = ONE_W + SPAN_W;
  localparam int N_W    = 2 * FRAC_BITS + 12;
  localparam int C_W    = 2 * FRAC_BITS + 10;
  localparam int Y_W    = C_W + CH_W;
  localparam int PQ_W   = Z_W + RECIP_W;

  localparam logic signed [CMP_W-1:0] ONE_S  = CMP_W'(1 << FRAC_BITS);
  localparam logic        [ONE_W-1:0] ONE_U  = ONE_W'(1 << FRAC_BITS);
  localparam logic        [ONE_W-1:0] HALF_U = ONE_W'(1 << (FRAC_BITS - 1));
  // full scale of a channel numerator: 600 * one * one
  localparam logic        [N_W-1:0]   E_U    =
    {{(N_W-SPAN_W){1'b0}}, SPAN_W'(SECTOR_SPAN)} << (2 * FRAC_BITS);

  // ---------------- stage control ----------------
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ch.ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // ---------------- stage 1: wrap hue, clamp S and L ----------------
  logic [HUE_W-1:0] s1_hue_r, s1_hue_nxt;
  logic [ONE_W-1:0] s1_s_r, s1_s_nxt;
  logic [ONE_W-1:0] s1_l_r, s1_l_nxt;
  logic [ONE_W-1:0] s1_a_r, s1_a_nxt;

  logic [HUE_OFS_W-1:0]   hue_ofs;
  logic signed [CMP_W-1:0] s_ext, l_ext;
  logic [ONE_W:0]          a_wide;

  always_comb begin
    // shift into positive range, then remove whole turns
    hue_ofs = HUE_OFS_W'($signed(HUE_OFS_W'(in_ch.hue_tenths)) +
                         $signed(HUE_OFS_W'(3 * HUE_WRAP)));
    priority if (hue_ofs >= HUE_OFS_W'(5 * HUE_WRAP)) begin
      s1_hue_nxt = HUE_W'(hue_ofs - HUE_OFS_W'(5 * HUE_WRAP));
    end else if (hue_ofs >= HUE_OFS_W'(4 * HUE_WRAP)) begin
      s1_hue_nxt = HUE_W'(hue_ofs - HUE_OFS_W'(4 * HUE_WRAP));
    end else if (hue_ofs >= HUE_OFS_W'(3 * HUE_WRAP)) begin
      s1_hue_nxt = HUE_W'(hue_ofs - HUE_OFS_W'(3 * HUE_WRAP));
    end else if (hue_ofs >= HUE_OFS_W'(2 * HUE_WRAP)) begin
      s1_hue_nxt = HUE_W'(hue_ofs - HUE_OFS_W'(2 * HUE_WRAP));
    end else if (hue_ofs >= HUE_OFS_W'(HUE_WRAP)) begin
      s1_hue_nxt = HUE_W'(hue_ofs - HUE_OFS_W'(HUE_WRAP));
    end else begin
      s1_hue_nxt = HUE_W'(hue_ofs);
    end

    s_ext = CMP_W'(in_ch.saturation_q12);
    l_ext = CMP_W'(in_ch.lightness_q12);
    if (s_ext < 0) begin
      s1_s_nxt = '0;
    end else if (s_ext > ONE_S) begin
      s1_s_nxt = ONE_U;
    end else begin
      s1_s_nxt = s_ext[ONE_W-1:0];
    end
    if (l_ext < 0) begin
      s1_l_nxt = '0;
    end else if (l_ext > ONE_S) begin
      s1_l_nxt = ONE_U;
    end else begin
      s1_l_nxt = l_ext[ONE_W-1:0];
    end

    // one - |2L - one|
    if (s1_l_nxt < HALF_U) begin
      a_wide = {s1_l_nxt, 1'b0};
    end else begin
      a_wide = {ONE_U - s1_l_nxt, 1'b0};
    end
    s1_a_nxt = a_wide[ONE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_hue_r <= s1_hue_nxt;
      s1_s_r   <= s1_s_nxt;
      s1_l_r   <= s1_l_nxt;
      s1_a_r   <= s1_a_nxt;
    end
  end

  // ---------------- stage 2: sector, chroma product K ----------------
  logic [2:0]        s2_sec_r, s2_sec_nxt;
  logic [SPAN_W-1:0] s2_fx_r, s2_fx_nxt;
  logic [K_W-1:0]    s2_k_r, s2_k_nxt;
  logic [LM_W-1:0]   s2_lm_r, s2_lm_nxt;
  logic [HUE_W-1:0]  sec_base;
  logic [SPAN_W-1:0] f_in;

  always_comb begin
    priority if (s1_hue_r >= HUE_W'(5 * SECTOR_SPAN)) begin
      s2_sec_nxt = 3'd5;
      sec_base   = HUE_W'(5 * SECTOR_SPAN);
    end else if (s1_hue_r >= HUE_W'(4 * SECTOR_SPAN)) begin
      s2_sec_nxt = 3'd4;
      sec_base   = HUE_W'(4 * SECTOR_SPAN);
    end else if (s1_hue_r >= HUE_W'(3 * SECTOR_SPAN)) begin
      s2_sec_nxt = 3'd3;
      sec_base   = HUE_W'(3 * SECTOR_SPAN);
    end else if (s1_hue_r >= HUE_W'(2 * SECTOR_SPAN)) begin
      s2_sec_nxt = 3'd2;
      sec_base   = HUE_W'(2 * SECTOR_SPAN);
    end else if (s1_hue_r >= HUE_W'(SECTOR_SPAN)) begin
      s2_sec_nxt = 3'd1;
      sec_base   = HUE_W'(SECTOR_SPAN);
    end else begin
      s2_sec_nxt = 3'd0;
      sec_base   = '0;
    end
    f_in = SPAN_W'(s1_hue_r - sec_base);
    // odd sectors run the second component downhill
    s2_fx_nxt = s2_sec_nxt[0] ? (SPAN_W'(SECTOR_SPAN) - f_in) : f_in;
    s2_k_nxt  = K_W'(s1_a_r) * K_W'(s1_s_r);
    s2_lm_nxt = LM_W'(s1_l_r) * LM_W'(SECTOR_SPAN);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_sec_r <= s2_sec_nxt;
      s2_fx_r  <= s2_fx_nxt;
      s2_k_r   <= s2_k_nxt;
      s2_lm_r  <= s2_lm_nxt;
    end
  end

  // ---------------- stage 3: K times channel weight ----------------
  // channel numerator over 600*one^2 is 600*L*one + K*u, with
  // u = +300 for chroma, fx-300 for the second component, -300 otherwise
  logic signed [U_W-1:0] u_c, u_x, u_z;
  logic signed [U_W-1:0] u_ch [NUM_CH];
  logic signed [N_W-1:0] s3_p_r [NUM_CH];
  logic signed [N_W-1:0] s3_p_nxt [NUM_CH];
  logic [LM_W-1:0]       s3_lm_r;

  always_comb begin
    u_c = U_W'(U_HALF);
    u_z = -U_W'(U_HALF);
    u_x = U_W'($signed({1'b0, s2_fx_r}) - $signed((SPAN_W+1)'(U_HALF)));
    unique case (s2_sec_r)
      3'd0: begin
        u_ch[CH_RED] = u_c; u_ch[CH_GREEN] = u_x; u_ch[CH_BLUE] = u_z;
      end
      3'd1: begin
        u_ch[CH_RED] = u_x; u_ch[CH_GREEN] = u_c; u_ch[CH_BLUE] = u_z;
      end
      3'd2: begin
        u_ch[CH_RED] = u_z; u_ch[CH_GREEN] = u_c; u_ch[CH_BLUE] = u_x;
      end
      3'd3: begin
        u_ch[CH_RED] = u_z; u_ch[CH_GREEN] = u_x; u_ch[CH_BLUE] = u_c;
      end
      3'd4: begin
        u_ch[CH_RED] = u_x; u_ch[CH_GREEN] = u_z; u_ch[CH_BLUE] = u_c;
      end
      default: begin
        u_ch[CH_RED] = u_c; u_ch[CH_GREEN] = u_z; u_ch[CH_BLUE] = u_x;
      end
    endcase
    for (int c = 0; c < NUM_CH; c++) begin
      s3_p_nxt[c] = N_W'($signed({1'b0, s2_k_r})) * N_W'(u_ch[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_lm_r <= s2_lm_r;
      for (int c = 0; c < NUM_CH; c++) begin
        s3_p_r[c] <= s3_p_nxt[c];
      end
    end
  end

  // ---------------- stage 4: numerator, clamp to 0..full scale ----------------
  logic signed [N_W-1:0] n_ch [NUM_CH];
  logic [C_W-1:0]        s4_n_r [NUM_CH];
  logic [C_W-1:0]        s4_n_nxt [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      n_ch[c] = $signed({1'b0, s3_lm_r, {FRAC_BITS{1'b0}}}) + s3_p_r[c];
      if (n_ch[c] < 0) begin
        s4_n_nxt[c] = '0;
      end else if (n_ch[c] > $signed(E_U)) begin
        s4_n_nxt[c] = E_U[C_W-1:0];
      end else begin
        s4_n_nxt[c] = n_ch[c][C_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        s4_n_r[c] <= s4_n_nxt[c];
      end
    end
  end

  // ---------------- stage 5: n*255 + half, drop one^2 ----------------
  logic [Y_W-1:0] y_ch [NUM_CH];
  logic [Z_W-1:0] s5_z_r [NUM_CH];
  logic [Z_W-1:0] s5_z_nxt [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      y_ch[c] = {s4_n_r[c], {CH_W{1'b0}}} - Y_W'(s4_n_r[c]) + Y_W'(E_U >> 1);
      s5_z_nxt[c] = y_ch[c][Y_W-1 -: Z_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        s5_z_r[c] <= s5_z_nxt[c];
      end
    end
  end

  // ---------------- stage 6: reciprocal estimate of z / 600 ----------------
  logic [PQ_W-1:0] pq_ch [NUM_CH];
  logic [Q_W-1:0]  s6_q_r [NUM_CH];
  logic [Q_W-1:0]  s6_q_nxt [NUM_CH];
  logic [Z_W-1:0]  s6_z_r [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      pq_ch[c]    = PQ_W'(s5_z_r[c]) * PQ_W'(RECIP);
      s6_q_nxt[c] = pq_ch[c][RECIP_SHIFT +: Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        s6_q_r[c] <= s6_q_nxt[c];
        s6_z_r[c] <= s5_z_r[c];
      end
    end
  end

  // ---------------- stage 7: correct quotient, clamp to 255, output register ----------------
  logic [Z_W-1:0]  rem_ch [NUM_CH];
  logic [Q_W-1:0]  qf_ch [NUM_CH];
  logic [CH_W-1:0] s7_ch_r [NUM_CH];
  logic [CH_W-1:0] s7_ch_nxt [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      rem_ch[c] = s6_z_r[c] - Z_W'(s6_q_r[c]) * Z_W'(SECTOR_SPAN);
      qf_ch[c]  = s6_q_r[c] + Q_W'(rem_ch[c] >= Z_W'(SECTOR_SPAN));
      if (qf_ch[c] > Q_W'(CH_MAX)) begin
        s7_ch_nxt[c] = CH_W'(CH_MAX);
      end else begin
        s7_ch_nxt[c] = qf_ch[c][CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        s7_ch_r[c] <= s7_ch_nxt[c];
      end
    end
  end

  assign out_ch.valid = v_r[NUM_STAGES-1];
  assign out_ch.red   = s7_ch_r[CH_RED];
  assign out_ch.green = s7_ch_r[CH_GREEN];
  assign out_ch.blue  = s7_ch_r[CH_BLUE];

endmodule

`default_nettype wire

/* rtl/core/h2r_checker.sv */
// Port-level checks for hsl_to_rgb_converter, attached by bind.
// Depends on h2r_pkg and the top level's channel interfaces.
`default_nettype none

module h2r_checker
  import h2r_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic [CH_W-1:0] red,
  input wire logic [CH_W-1:0] green,
  input wire logic [CH_W-1:0] blue
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("result changed or dropped while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with the output stage empty nothing can back up to the input
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with output stage empty");

  // a ready output side never blocks the input
  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is being taken");

endmodule

bind hsl_to_rgb_converter h2r_checker u_h2r_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .red       (out_ch.red),
  .green     (out_ch.green),
  .blue      (out_ch.blue)
);

`default_nettype wire
